@@ hw/rtl/gble_pkg.sv @@
// Shared types and constants for the gap-buffer line editor.
package gble_pkg;

    localparam int FIELD_W  = 11;  // position, cursor and length fields
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 3'd0,
        KIND_BACKSPACE = 3'd1,
        KIND_DELETE    = 3'd2,
        KIND_SET_CUR   = 3'd3,
        KIND_READ      = 3'd4,
        KIND_DEL_RANGE = 3'd5,
        KIND_TRIM      = 3'd6
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECIDE = 6'b000010,
        ST_MOVE   = 6'b000100,
        ST_POST   = 6'b001000,
        ST_READ   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        POST_NONE  = 2'd0,
        POST_RANGE = 2'd1,
        POST_TRIM  = 2'd2
    } post_t;

endpackage

@@ hw/rtl/gble_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
module gble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/gap_buffer_line_editor_top.sv @@
// Gap-buffer line editor: command sequencer around a single character store.
//
// Usage:
//   Slave channel (s_*): one command per transaction. s_tuser carries the
//   command kind; s_tdata carries char_in, position and position_end.
//   Master channel (m_*): exactly one result transaction per command with
//   char_out, cursor, text_length and error.
// Command paths (from accept to result, output register free):
//   insert, backspace, forward delete, refused and no-op commands: decide, then done.
//   read: decide issues one synchronous store read, then read and done.
//   set cursor, delete range, trim: decide, move, post, then done; move copies
//   the characters across the gap, and the store's one read port and one write
//   port move one character per cycle, reads and write-backs overlapped.
// Throughput: one command in flight; the next is taken once the current one
//   has handed its result to the output register.
// Reset: cursor 0, empty line, whole store is gap. The store itself is not
//   cleared; text only ever occupies written entries.
// Stall: a result waits in the output register while the next command is
//   accepted and processed; that command holds in its final state until the
//   output register frees up.
module gap_buffer_line_editor_top #(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] char_in, [18:8] position, [29:19] position_end, [31:30] zero
    input  logic [31:0] s_tdata,
    // s_tuser: [2:0] kind
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [7:0] char_out, [18:8] cursor, [29:19] text_length, [30] error, [31] zero
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int AW   = $clog2(CAPACITY);        // store address
    localparam int PW   = $clog2(CAPACITY + 1);    // pointer, 0..CAPACITY
    localparam int FW   = gble_pkg::FIELD_W;
    localparam int CMPW = (PW > FW) ? PW : FW;     // common compare width
    localparam int RW   = CMPW + 1;                // physical read index
    localparam int EW   = (PW > FW + 1) ? PW : FW + 1; // range count width
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    gble_pkg::state_t state_reg, state_next;
    gble_pkg::kind_t  kind_reg, kind_next;
    gble_pkg::post_t  post_reg, post_next;

    logic [7:0]    char_reg, char_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic [FW-1:0] pos_end_reg, pos_end_next;
    logic [PW-1:0] gb_reg, gb_next;         // gap begin == cursor
    logic [PW-1:0] ag_reg, ag_next;         // first slot after the gap
    logic [PW-1:0] target_reg, target_next;
    logic          err_reg, err_next;
    logic [7:0]    char_out_reg, char_out_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          wpend_reg, wpend_next;   // copy write-back due this cycle
    logic [AW-1:0] wpend_addr_reg, wpend_addr_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;

    // store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // derived values
    logic [PW-1:0]   len;
    logic [CMPW-1:0] len_x, pos_x, gb_x;
    logic [PW-1:0]   gb_dec, ag_dec, gb_inc, ag_inc;
    logic [PW-1:0]   clamp_tgt;
    logic            over_end;
    logic [RW-1:0]   phys;
    logic [EW-1:0]   cnt, avail;
    logic            out_free;

    assign len    = gb_reg + (CAP_P - ag_reg);
    assign len_x  = CMPW'(len);
    assign pos_x  = CMPW'(pos_reg);
    assign gb_x   = CMPW'(gb_reg);
    assign gb_dec = gb_reg - PW'(1);
    assign ag_dec = ag_reg - PW'(1);
    assign gb_inc = gb_reg + PW'(1);
    assign ag_inc = ag_reg + PW'(1);

    // cursor target, clamped to the line end
    assign over_end  = pos_x > len_x;
    assign clamp_tgt = over_end ? len : pos_x[PW-1:0];

    // logical to physical index for reads
    assign phys = (pos_x < gb_x) ? RW'(pos_x) : (RW'(pos_x) + RW'(ag_reg - gb_reg));

    // characters a range delete may remove, and what lies after the cursor
    assign cnt   = EW'(pos_end_reg) - EW'(pos_reg) + EW'(1);
    assign avail = EW'(CAP_P - ag_reg);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        post_next       = post_reg;
        char_next       = char_reg;
        pos_next        = pos_reg;
        pos_end_next    = pos_end_reg;
        gb_next         = gb_reg;
        ag_next         = ag_reg;
        target_next     = target_reg;
        err_next        = err_reg;
        char_out_next   = char_out_reg;
        rd_ok_next      = rd_ok_reg;
        wpend_next      = 1'b0;
        wpend_addr_next = wpend_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        ram_we    = wpend_reg;
        ram_waddr = wpend_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (state_reg)
            gble_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = gble_pkg::kind_t'(s_tuser);
                    char_next    = s_tdata[7:0];
                    pos_next     = s_tdata[18:8];
                    pos_end_next = s_tdata[29:19];
                    state_next   = gble_pkg::ST_DECIDE;
                end
            end

            gble_pkg::ST_DECIDE: begin
                err_next      = 1'b0;
                char_out_next = '0;
                post_next     = gble_pkg::POST_NONE;
                target_next   = clamp_tgt;
                state_next    = gble_pkg::ST_DONE;
                case (kind_reg)
                    gble_pkg::KIND_INSERT: begin
                        if (gb_reg >= ag_reg) begin
                            err_next = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = gb_reg[AW-1:0];
                            ram_wdata = char_reg;
                            gb_next   = gb_inc;
                        end
                    end
                    gble_pkg::KIND_BACKSPACE: begin
                        if (gb_reg == '0) begin
                            err_next = 1'b1;
                        end else begin
                            gb_next = gb_dec;
                        end
                    end
                    gble_pkg::KIND_DELETE: begin
                        if (ag_reg >= CAP_P) begin
                            err_next = 1'b1;
                        end else begin
                            ag_next = ag_inc;
                        end
                    end
                    gble_pkg::KIND_SET_CUR: begin
                        err_next   = over_end && (gb_reg == len);
                        state_next = gble_pkg::ST_MOVE;
                    end
                    gble_pkg::KIND_READ: begin
                        ram_re     = 1'b1;
                        ram_raddr  = phys[AW-1:0];
                        rd_ok_next = phys < RW'(CAP_P);
                        state_next = gble_pkg::ST_READ;
                    end
                    gble_pkg::KIND_DEL_RANGE: begin
                        if (pos_end_reg >= pos_reg) begin
                            err_next   = over_end && (gb_reg == len);
                            post_next  = gble_pkg::POST_RANGE;
                            state_next = gble_pkg::ST_MOVE;
                        end
                    end
                    gble_pkg::KIND_TRIM: begin
                        if (pos_x < len_x) begin
                            post_next  = gble_pkg::POST_TRIM;
                            state_next = gble_pkg::ST_MOVE;
                        end
                    end
                    default: begin
                        err_next = 1'b1;
                    end
                endcase
            end

            // One character across the gap per cycle; the byte read now is
            // written back next cycle through wpend. The last write-back lands
            // in the cycle that leaves this state.
            gble_pkg::ST_MOVE: begin
                if (gb_reg > target_reg) begin
                    ram_re          = 1'b1;
                    ram_raddr       = gb_dec[AW-1:0];
                    wpend_next      = 1'b1;
                    wpend_addr_next = ag_dec[AW-1:0];
                    gb_next         = gb_dec;
                    ag_next         = ag_dec;
                end else if (gb_reg < target_reg && ag_reg < CAP_P) begin
                    ram_re          = 1'b1;
                    ram_raddr       = ag_reg[AW-1:0];
                    wpend_next      = 1'b1;
                    wpend_addr_next = gb_reg[AW-1:0];
                    gb_next         = gb_inc;
                    ag_next         = ag_inc;
                end else begin
                    state_next = gble_pkg::ST_POST;
                end
            end

            // drop text after the cursor: up to the range's count for range delete, all of it for trim
            gble_pkg::ST_POST: begin
                case (post_reg)
                    gble_pkg::POST_RANGE: begin
                        if (cnt < avail) begin
                            ag_next = ag_reg + cnt[PW-1:0];
                        end else begin
                            ag_next = CAP_P;
                        end
                    end
                    gble_pkg::POST_TRIM: ag_next = CAP_P;
                    default: ;
                endcase
                state_next = gble_pkg::ST_DONE;
            end

            gble_pkg::ST_READ: begin
                char_out_next = rd_ok_reg ? ram_rdata : 8'd0;
                state_next    = gble_pkg::ST_DONE;
            end

            gble_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, err_reg, len_x[FW-1:0], gb_x[FW-1:0], char_out_reg};
                    state_next    = gble_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gble_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gble_pkg::ST_IDLE;
            gb_reg       <= '0;
            ag_reg       <= CAP_P;
            wpend_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gb_reg       <= gb_next;
            ag_reg       <= ag_next;
            wpend_reg    <= wpend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        post_reg       <= post_next;
        char_reg       <= char_next;
        pos_reg        <= pos_next;
        pos_end_reg    <= pos_end_next;
        target_reg     <= target_next;
        err_reg        <= err_next;
        char_out_reg   <= char_out_next;
        rd_ok_reg      <= rd_ok_next;
        wpend_addr_reg <= wpend_addr_next;
        m_tdata_reg    <= m_tdata_next;
    end

    gble_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == gble_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hw/rtl/gble_checker.sv @@
// Port-level checks for the gap-buffer line editor, bound to the top level.
module gble_checker #(
    parameter int CAPACITY = 1024
) (
    input logic        aclk,
    input logic        aresetn,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // a stalled result transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // cursor never lies beyond the line end (checked for CAPACITY up to 2047)
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 2047) || (m_tdata[18:8] <= m_tdata[29:19]))
        else $error("cursor beyond text length");

    // the line never outgrows the store (checked for CAPACITY up to 2047)
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 2047) || (int'(m_tdata[29:19]) <= CAPACITY))
        else $error("text length exceeds capacity");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind gap_buffer_line_editor_top gble_checker #(.CAPACITY(CAPACITY)) u_gble_checker (.*);
